/* design/mdvt_pkg.sv */
package mdvt_pkg;

  localparam int MAX_MBS    = 2400;
  localparam int HIST_DEPTH = 8;
  localparam int WORDS32    = (MAX_MBS + 31) / 32;
  localparam int WORDS64    = (WORDS32 + 1) / 2;
  localparam int HIST_WORDS = HIST_DEPTH * WORDS64;

  localparam int WORD_W  = 64;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WIDX_W  = $clog2(WORDS64);
  localparam int HADDR_W = $clog2(HIST_WORDS);
  localparam int SLOT_W  = $clog2(HIST_DEPTH);

  localparam int MB_W   = 12;
  localparam int STEP_W = $clog2(MB_W);
  localparam int VER_W  = 32;
  localparam int QW_W   = 7;
  localparam int CMD_W  = 3;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 104;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_PIC_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QWORDS   = 2'd2;

  localparam logic [MB_W-1:0] PIC_SIZE_RST = 12'd2400;
  localparam logic [MB_W-1:0] WIDTH_RST    = 12'd1;
  localparam logic [QW_W-1:0] QWORDS_RST   = 7'd75;

  localparam logic [CMD_W-1:0] CMD_BEGIN    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MARK     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MARK_ALL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_END      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RST_HIST = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CHANGED  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TOUCHED  = 3'd6;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_stat_t;

endpackage

/* design/mdvt_ram.sv */
module mdvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 38
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/mdvt_rem.sv */
module mdvt_rem import mdvt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [MB_W-1:0] dividend,
  input  logic [MB_W-1:0] divisor,
  output rem_stat_t       stat
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [MB_W-1:0]   dvd;
  logic [MB_W-1:0]   divr;
  logic [MB_W-1:0]   rem;
  logic [MB_W:0]     trial;

  assign trial = {rem, dvd[MB_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        divr <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd  <= {dvd[MB_W-2:0], 1'b0};
        rem  <= (trial >= {1'b0, divr}) ? MB_W'(trial - {1'b0, divr}) : MB_W'(trial);
        step <= step + 1'b1;
        if (step == STEP_W'(MB_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule

/* design/macroblock_dirty_version_tracker_unit.sv */
// Sequencing: begin, mark all and reset history finish on acceptance, mark adds a write state;
// end picture copies the current bitmap into history (one word per cycle), then gives its beat.
// Changed-since: a check state, then per 64-bit word one history read per version in the span;
// touched: waits for the 12-step remainder unit, then makes 3 probe reads.
// One item at a time; the next is accepted as soon as the sequencer is idle again.
// Reset (synchronous, active high) clears bitmaps, history and versions at once.
module macroblock_dirty_version_tracker_unit import mdvt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // mb_index, from_version, to_version, zero pad
  input  logic [CMD_W-1:0]      s_tuser,  // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // ok, version, mask_word, word_index, zero pad
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MARK_WR  = 4'd1;
  localparam logic [3:0] S_END_RUN  = 4'd2;
  localparam logic [3:0] S_END_TAIL = 4'd3;
  localparam logic [3:0] S_QRY_CHK  = 4'd4;
  localparam logic [3:0] S_QRY_RUN  = 4'd5;
  localparam logic [3:0] S_QRY_TAIL = 4'd6;
  localparam logic [3:0] S_TCH_DIV  = 4'd7;
  localparam logic [3:0] S_TCH_RUN  = 4'd8;
  localparam logic [3:0] S_TCH_TAIL = 4'd9;
  localparam logic [3:0] S_RESULT   = 4'd10;

  typedef struct packed {
    logic              ok;
    logic [VER_W-1:0]  ver;
    logic [WORD_W-1:0] mask;
    logic [5:0]        widx;
    logic              last;
  } res_t;

  function automatic logic [HADDR_W-1:0] hist_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [WIDX_W-1:0] w);
    return HADDR_W'(s) * HADDR_W'(WORDS64) + HADDR_W'(w);
  endfunction

  function automatic logic [WORD_W-1:0] fill_word(input logic [WIDX_W-1:0] w);
    return (8'({w, 1'b1}) < 8'(WORDS32)) ? '1 : WORD_W'(32'hFFFF_FFFF);
  endfunction

  logic [3:0]         state;
  logic [MB_W-1:0]    pic_size;
  logic [MB_W-1:0]    width;
  logic [QW_W-1:0]    qwords;
  logic               all_written;
  logic [VER_W-1:0]   next_version;
  logic [VER_W-1:0]   valid_from;
  logic [WORDS64-1:0] lo_vld;
  logic [WORDS64-1:0] hi_vld;
  logic [HIST_DEPTH-1:0] slot_vld;

  logic [MB_W-1:0]    mb_r;
  logic [VER_W-1:0]   from_r;
  logic [VER_W-1:0]   to_r;
  logic [VER_W-1:0]   ver_r;
  logic [WIDX_W-1:0]  idx;
  logic [WIDX_W-1:0]  rd_idx;
  logic [WIDX_W-1:0]  cnt;
  logic               odd;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  slot_start;
  logic [SLOT_W-1:0]  span;
  logic [SLOT_W-1:0]  vcnt;
  logic [WORD_W-1:0]  acc;
  logic               wr_pend;
  logic               hrd_ok;
  logic [2:0]         tcond;
  logic [1:0]         probe;
  logic               trd_cond;
  logic [BIT_W-1:0]   trd_bit;
  logic               hit;
  res_t               res;
  res_t               out_r;

  logic [MB_W-1:0]    s_mb;
  logic [VER_W-1:0]   s_from;
  logic [VER_W-1:0]   s_to;
  logic               accept;
  logic               out_free;
  logic [7:0]         clr_raw;
  logic [7:0]         clr_words;
  logic [QW_W-1:0]    qw_eff;
  logic [WIDX_W-1:0]  cnt_next;
  logic [VER_W-1:0]   diff;
  logic [VER_W-1:0]   from_p1;
  logic               reject;
  logic [MB_W-1:0]    mb_m1;
  logic [MB_W-1:0]    mb_mw;
  logic [MB_W-1:0]    probe_addr;
  logic               probe_cond;
  logic [WORD_W-1:0]  tail_mask;
  logic               tail_last;

  logic               cur_we;
  logic [WIDX_W-1:0]  cur_raddr;
  logic [WORD_W-1:0]  cur_wdata;
  logic [WORD_W-1:0]  cur_rdata;
  logic [WORD_W-1:0]  cur_q;
  logic               hist_we;
  logic [HADDR_W-1:0] hist_waddr;
  logic [HADDR_W-1:0] hist_raddr;
  logic [WORD_W-1:0]  hist_wdata;
  logic [WORD_W-1:0]  hist_rdata;
  logic [WORD_W-1:0]  hist_qm;
  rem_stat_t          rem_stat;

  assign s_mb   = s_tdata[MB_W-1:0];
  assign s_from = s_tdata[MB_W+VER_W-1:MB_W];
  assign s_to   = s_tdata[MB_W+2*VER_W-1:MB_W+VER_W];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign clr_raw   = 8'((13'(pic_size) + 13'd31) >> 5);
  assign clr_words = (clr_raw > 8'(WORDS32)) ? 8'(WORDS32) : clr_raw;

  assign qw_eff   = (qwords > QW_W'(WORDS32)) ? QW_W'(WORDS32) : qwords;
  assign cnt_next = WIDX_W'((8'(qw_eff) + 8'd1) >> 1);

  assign diff    = to_r - from_r;
  assign from_p1 = from_r + 1'b1;
  assign reject  = (from_r == '0) || (to_r <= from_r) || (to_r >= next_version) ||
                   (diff >= VER_W'(HIST_DEPTH)) || (from_p1 < valid_from);

  assign mb_m1 = mb_r - 1'b1;
  assign mb_mw = mb_r - width;

  always_comb begin
    case (probe)
      2'd0:    probe_addr = mb_r;
      2'd1:    probe_addr = mb_m1;
      default: probe_addr = mb_mw;
    endcase
  end
  assign probe_cond = (probe == 2'd0) ? tcond[0] : (probe == 2'd1) ? tcond[1] : tcond[2];

  always_comb begin
    case (state)
      S_IDLE:    cur_raddr = WIDX_W'(s_mb >> BIT_W);
      S_END_RUN: cur_raddr = idx;
      S_TCH_RUN: cur_raddr = probe_cond ? WIDX_W'(probe_addr >> BIT_W) : '0;
      default:   cur_raddr = '0;
    endcase
  end

  assign cur_q     = cur_rdata & {{32{hi_vld[rd_idx]}}, {32{lo_vld[rd_idx]}}};
  assign cur_we    = (state == S_MARK_WR);
  assign cur_wdata = cur_q | (WORD_W'(1) << mb_r[BIT_W-1:0]);

  assign hist_we    = wr_pend;
  assign hist_waddr = hist_addr(slot, rd_idx);
  assign hist_wdata = all_written ? fill_word(rd_idx) : cur_q;
  assign hist_raddr = hist_addr(slot, idx);
  assign hist_qm    = hrd_ok ? hist_rdata : '0;

  assign tail_last = (idx == cnt - 1'b1);
  always_comb begin
    tail_mask = acc | hist_qm;
    if (tail_last && odd) begin
      tail_mask[WORD_W-1:32] = '0;
    end
  end

  mdvt_ram #(.WIDTH(WORD_W), .DEPTH(WORDS64)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (rd_idx),
    .wdata (cur_wdata),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  mdvt_ram #(.WIDTH(WORD_W), .DEPTH(HIST_WORDS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  mdvt_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && (s_tuser == CMD_TOUCHED)),
    .dividend (s_mb),
    .divisor  (width),
    .stat     (rem_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pic_size     <= PIC_SIZE_RST;
      width        <= WIDTH_RST;
      qwords       <= QWORDS_RST;
      all_written  <= 1'b0;
      next_version <= VER_W'(1);
      valid_from   <= VER_W'(1);
      lo_vld       <= '0;
      hi_vld       <= '0;
      slot_vld     <= '0;
      m_tvalid     <= 1'b0;
      wr_pend      <= 1'b0;
      hrd_ok       <= 1'b0;
      trd_cond     <= 1'b0;
    end else begin
      wr_pend  <= (state == S_END_RUN);
      hrd_ok   <= (state == S_QRY_RUN) && slot_vld[slot];
      trd_cond <= (state == S_TCH_RUN) && probe_cond;
      trd_bit  <= probe_addr[BIT_W-1:0];
      rd_idx   <= cur_raddr;
      acc      <= acc | hist_qm;
      hit      <= hit | (trd_cond && cur_q[trd_bit]);

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PIC_SIZE: pic_size <= cfg_data;
          CFG_WIDTH:    width    <= cfg_data;
          CFG_QWORDS:   qwords   <= cfg_data[QW_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mb_r   <= s_mb;
            from_r <= s_from;
            to_r   <= s_to;
            case (s_tuser)
              CMD_BEGIN: begin
                for (int w = 0; w < WORDS64; w++) begin
                  if (8'(2 * w) < clr_words) lo_vld[w] <= 1'b0;
                  if (8'(2 * w + 1) < clr_words) hi_vld[w] <= 1'b0;
                end
                all_written <= 1'b0;
              end
              CMD_MARK: begin
                if (s_mb < MB_W'(MAX_MBS)) state <= S_MARK_WR;
              end
              CMD_MARK_ALL: all_written <= 1'b1;
              CMD_END: begin
                ver_r        <= next_version;
                next_version <= next_version + 1'b1;
                slot         <= SLOT_W'(next_version);
                idx          <= '0;
                state        <= S_END_RUN;
              end
              CMD_RST_HIST: begin
                slot_vld   <= '0;
                valid_from <= next_version;
              end
              CMD_CHANGED: state <= S_QRY_CHK;
              CMD_TOUCHED: state <= S_TCH_DIV;
              default: ;
            endcase
          end
        end
        S_MARK_WR: begin
          lo_vld[rd_idx] <= 1'b1;
          hi_vld[rd_idx] <= 1'b1;
          state          <= S_IDLE;
        end
        S_END_RUN: begin
          idx <= idx + 1'b1;
          if (idx == WIDX_W'(WORDS64 - 1)) state <= S_END_TAIL;
        end
        S_END_TAIL: begin
          slot_vld[slot] <= 1'b1;
          res.ok   <= 1'b1;
          res.ver  <= ver_r;
          res.mask <= '0;
          res.widx <= '0;
          res.last <= 1'b1;
          state    <= S_RESULT;
        end
        S_QRY_CHK: begin
          acc        <= '0;
          idx        <= '0;
          span       <= SLOT_W'(diff);
          vcnt       <= SLOT_W'(diff);
          slot       <= SLOT_W'(from_p1);
          slot_start <= SLOT_W'(from_p1);
          cnt        <= cnt_next;
          odd        <= qw_eff[0];
          res.ver    <= '0;
          res.mask   <= '0;
          res.widx   <= '0;
          res.last   <= 1'b1;
          if (reject) begin
            res.ok <= 1'b0;
            state  <= S_RESULT;
          end else if (qw_eff == '0) begin
            res.ok <= 1'b1;
            state  <= S_RESULT;
          end else begin
            state <= S_QRY_RUN;
          end
        end
        S_QRY_RUN: begin
          slot <= slot + 1'b1;
          vcnt <= vcnt - 1'b1;
          if (vcnt == SLOT_W'(1)) state <= S_QRY_TAIL;
        end
        S_QRY_TAIL: begin
          res.ok   <= 1'b1;
          res.ver  <= '0;
          res.mask <= tail_mask;
          res.widx <= 6'(idx);
          res.last <= tail_last;
          state    <= S_RESULT;
        end
        S_TCH_DIV: begin
          if (rem_stat.done) begin
            tcond[0] <= (mb_r < MB_W'(MAX_MBS));
            tcond[1] <= (width != '0) && !rem_stat.rem_zero && (mb_m1 < MB_W'(MAX_MBS));
            tcond[2] <= (width != '0) && (mb_r >= width) && (mb_mw < MB_W'(MAX_MBS));
            hit      <= all_written;
            probe    <= '0;
            state    <= S_TCH_RUN;
          end
        end
        S_TCH_RUN: begin
          probe <= probe + 1'b1;
          if (probe == 2'd2) state <= S_TCH_TAIL;
        end
        S_TCH_TAIL: begin
          res.ok   <= hit | (trd_cond && cur_q[trd_bit]);
          res.ver  <= '0;
          res.mask <= '0;
          res.widx <= '0;
          res.last <= 1'b1;
          state    <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_r    <= res;
            m_tvalid <= 1'b1;
            if (res.last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              acc   <= '0;
              slot  <= slot_start;
              vcnt  <= span;
              state <= S_QRY_RUN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {1'b0, out_r.widx, out_r.mask, out_r.ver, out_r.ok};
  assign m_tlast = out_r.last;

`ifndef SYNTHESIS
  a_rem_done_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_stat.done |-> state == S_TCH_DIV)
    else $error("remainder done outside touched wait");

  a_hist_we_in_end: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> (state == S_END_RUN || state == S_END_TAIL))
    else $error("history write outside end picture");

  a_widx_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_QRY_TAIL |-> idx < cnt)
    else $error("query word index beyond answer length");

  a_run_open: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> state != S_IDLE)
    else $error("sequencer idle with query answer unfinished");
`endif

endmodule
